// ----- hw/rtl/gwvp_pkg.sv -----
// ----------------------------------------------------------------------------
// gwvp_pkg
// Shared types, constants and helpers for the grid walker step core.
// ----------------------------------------------------------------------------
package gwvp_pkg;

  localparam int GRID_COLS   = 32;
  localparam int GRID_ROWS   = 16;
  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = 9;
  localparam int KIND_W      = 2;
  localparam int CNT_W       = 16;
  localparam int NUM_DIRS    = 4;

  localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
  localparam int GRID_LIMIT  = (GRID_CELLS < STORE_DEPTH) ? GRID_CELLS : STORE_DEPTH;

  localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W = $clog2((STORE_DEPTH - 1) / GRID_COLS + 1);

  // twice a count plus a distance across the whole store
  localparam int SCORE_W = CNT_W + 2;
  localparam logic [SCORE_W-1:0] SCORE_LIMIT = SCORE_W'(10000);
  localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;

  // reciprocal for index / GRID_COLS, exact for every 9-bit index
  localparam int DIV_SHIFT = 18;
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + GRID_COLS - 1) / GRID_COLS;
  localparam int PROD_W    = ADDR_W + DIV_SHIFT;

  localparam logic [ADDR_W-1:0] WALKER_RESET = ADDR_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN = 2'd0,
    KIND_WALL = 2'd1,
    KIND_MARK = 2'd2,
    KIND_GOAL = 2'd3
  } kind_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              ok;
  } cand_t;

  typedef cand_t [NUM_DIRS-1:0] cand_vec_t;

  typedef struct packed {
    logic              kind_we;
    logic [ADDR_W-1:0] kind_addr;
    kind_e             kind_data;
    logic              cnt_we;
    logic [ADDR_W-1:0] cnt_addr;
    logic [CNT_W-1:0]  cnt_data;
  } st_wr_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] idx;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    kind_e             kind;
    logic [CNT_W-1:0]  cnt;
  } sel_t;

  // neighbour of a cell in one direction; row ends wrap on the linear index
  function automatic cand_t neighbour(input dir_e dir, input logic [ADDR_W-1:0] pos,
                                      input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
    cand_t         c;
    logic [ADDR_W:0] wide;
    c    = '{idx: pos, row: row, col: col, ok: 1'b0};
    wide = '0;
    case (dir)
      DIR_RIGHT: begin
        wide  = {1'b0, pos} + (ADDR_W+1)'(1);
        c.idx = wide[ADDR_W-1:0];
        c.ok  = wide < (ADDR_W+1)'(GRID_LIMIT);
        if (col == COL_W'(GRID_COLS - 1)) begin
          c.row = row + ROW_W'(1);
          c.col = '0;
        end else begin
          c.col = col + COL_W'(1);
        end
      end
      DIR_LEFT: begin
        c.idx = pos - ADDR_W'(1);
        c.ok  = pos != '0;
        if (col == '0) begin
          c.row = row - ROW_W'(1);
          c.col = COL_W'(GRID_COLS - 1);
        end else begin
          c.col = col - COL_W'(1);
        end
      end
      DIR_DOWN: begin
        wide  = {1'b0, pos} + (ADDR_W+1)'(GRID_COLS);
        c.idx = wide[ADDR_W-1:0];
        c.ok  = wide < (ADDR_W+1)'(GRID_LIMIT);
        c.row = row + ROW_W'(1);
      end
      DIR_UP: begin
        c.idx = pos - ADDR_W'(GRID_COLS);
        c.ok  = pos >= ADDR_W'(GRID_COLS);
        c.row = row - ROW_W'(1);
      end
      default: begin
        c.ok = 1'b0;
      end
    endcase
    return c;
  endfunction

  function automatic cand_vec_t neighbours(input logic [ADDR_W-1:0] pos,
                                           input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col);
    cand_vec_t v;
    for (int d = 0; d < NUM_DIRS; d++) begin
      v[d] = neighbour(dir_e'(d), pos, row, col);
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/gwvp_store.sv -----
// ----------------------------------------------------------------------------
// gwvp_store
// Cell kind and visit count stores, one copy per neighbour direction so that
// all four neighbours are read together. Counts are swept to zero after
// reset; kind writes are forwarded to reads at the same edge.
// ----------------------------------------------------------------------------
module gwvp_store import gwvp_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  st_wr_t                           wr_i,
  input  logic [NUM_DIRS-1:0][ADDR_W-1:0]  rd_addr_i,
  output kind_e [NUM_DIRS-1:0]             rd_kind_o,
  output logic  [NUM_DIRS-1:0][CNT_W-1:0]  rd_cnt_o,
  output logic                             busy_o
);

  logic [KIND_W-1:0] kind_mem [NUM_DIRS][STORE_DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [NUM_DIRS][STORE_DEPTH];

  logic [NUM_DIRS-1:0][KIND_W-1:0] kind_rd_q;
  logic [NUM_DIRS-1:0][CNT_W-1:0]  cnt_rd_q;
  logic [NUM_DIRS-1:0]             byp_q, byp_d;
  kind_e                           byp_kind_q;

  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  logic              cnt_we;
  logic [ADDR_W-1:0] cnt_addr;
  logic [CNT_W-1:0]  cnt_data;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign cnt_we   = clr_busy_q | wr_i.cnt_we;
  assign cnt_addr = clr_busy_q ? clr_addr_q : wr_i.cnt_addr;
  assign cnt_data = clr_busy_q ? '0 : wr_i.cnt_data;

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      byp_d[d] = wr_i.kind_we && (wr_i.kind_addr == rd_addr_i[d]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (wr_i.kind_we) begin
        kind_mem[d][wr_i.kind_addr] <= wr_i.kind_data;
      end
      kind_rd_q[d] <= kind_mem[d][rd_addr_i[d]];
    end
  end

  // a count write never lands on a neighbour of the cell it is written to
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (cnt_we) begin
        cnt_mem[d][cnt_addr] <= cnt_data;
      end
      cnt_rd_q[d] <= cnt_mem[d][rd_addr_i[d]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= '0;
    end else begin
      byp_q <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_kind_q <= wr_i.kind_data;
  end

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      rd_kind_o[d] = byp_q[d] ? byp_kind_q : kind_e'(kind_rd_q[d]);
    end
  end

  assign rd_cnt_o = cnt_rd_q;
  assign busy_o   = clr_busy_q;

endmodule

// ----- hw/rtl/gwvp_select.sv -----
// ----------------------------------------------------------------------------
// gwvp_select
// Scores the four neighbours of the walker and picks the cheapest passable
// one; earlier directions win ties.
// ----------------------------------------------------------------------------
module gwvp_select import gwvp_pkg::*; (
  input  cand_vec_t                        cand_i,
  input  kind_e [NUM_DIRS-1:0]             kind_i,
  input  logic  [NUM_DIRS-1:0][CNT_W-1:0]  cnt_i,
  input  logic  [ROW_W-1:0]                goal_row_i,
  input  logic  [COL_W-1:0]                goal_col_i,
  output sel_t                             sel_o
);

  logic [NUM_DIRS-1:0][SCORE_W-1:0] score;
  logic [NUM_DIRS-1:0]              pass;
  logic [SCORE_W-1:0]               best;
  logic [CNT_W-1:0]                 win_cnt;

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      logic [ROW_W-1:0] dr;
      logic [COL_W-1:0] dc;
      dr = (cand_i[d].row > goal_row_i) ? cand_i[d].row - goal_row_i
                                        : goal_row_i - cand_i[d].row;
      dc = (cand_i[d].col > goal_col_i) ? cand_i[d].col - goal_col_i
                                        : goal_col_i - cand_i[d].col;
      score[d] = {1'b0, cnt_i[d], 1'b0} + SCORE_W'(dr) + SCORE_W'(dc);
      pass[d]  = cand_i[d].ok && (kind_i[d] == KIND_OPEN || kind_i[d] == KIND_GOAL);
    end
  end

  always_comb begin
    best        = SCORE_LIMIT;
    sel_o.found = 1'b0;
    sel_o.idx   = cand_i[0].idx;
    sel_o.row   = cand_i[0].row;
    sel_o.col   = cand_i[0].col;
    sel_o.kind  = kind_i[0];
    win_cnt     = cnt_i[0];
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (pass[d] && score[d] < best) begin
        best        = score[d];
        sel_o.found = 1'b1;
        sel_o.idx   = cand_i[d].idx;
        sel_o.row   = cand_i[d].row;
        sel_o.col   = cand_i[d].col;
        sel_o.kind  = kind_i[d];
        win_cnt     = cnt_i[d];
      end
    end
    sel_o.cnt = (win_cnt == COUNT_MAX) ? win_cnt : win_cnt + CNT_W'(1);
  end

endmodule

// ----- hw/rtl/grid_walker_visit_penalty_step_core.sv -----
// ----------------------------------------------------------------------------
// grid_walker_visit_penalty_step_core
// Greedy maze walker with a visit penalty over a stored grid of cell kinds.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one beat per item: a load
// writes one cell kind, a step moves the walker to its cheapest open
// neighbour. Every beat gives exactly one result beat on the output channel
// (out_valid_o / out_stall_i): walker position, moved flag, goal flag and
// the visit count of the walker's cell.
// The goal cell is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle (not enforced here). An accepted beat waits in the
// input register until its result enters the output register. One beat is
// taken every cycle while the output does not stall and the sweep is done;
// the four neighbour reads come from one store copy per direction, issued
// at the walker's next position. After reset the visit counts are swept to
// zero, one cell a cycle; in_stall_o is high meanwhile. The walker starts at
// cell 1, the goal at cell 0. When out_stall_i holds a result, one more beat
// enters the input register, then in_stall_o rises until the result drains.
// ----------------------------------------------------------------------------
module grid_walker_visit_penalty_step_core import gwvp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [ADDR_W-1:0] cell_index_i,
  input  logic [KIND_W-1:0] cell_kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] position_o,
  output logic              moved_o,
  output logic              at_goal_o,
  output logic [CNT_W-1:0]  visit_count_o
);

  logic              item_vld_q, item_vld_d;
  req_e              item_req_q;
  logic [ADDR_W-1:0] item_idx_q;
  kind_e             item_kind_q;

  logic [ADDR_W-1:0] walker_q, walker_d;
  logic [ROW_W-1:0]  wrow_q, wrow_d;
  logic [COL_W-1:0]  wcol_q, wcol_d;
  kind_e             wkind_q, wkind_d;
  logic [CNT_W-1:0]  wcnt_q, wcnt_d;

  logic [ROW_W-1:0]  goal_row_q;
  logic [COL_W-1:0]  goal_col_q;
  logic [PROD_W-1:0] goal_prod;
  logic [ROW_W-1:0]  goal_row_d;
  logic [ADDR_W-1:0] goal_base;

  logic              res_vld_q, res_vld_d;
  logic [ADDR_W-1:0] res_pos_q;
  logic              res_moved_q, res_moved_d;
  logic              res_goal_q;
  logic [CNT_W-1:0]  res_cnt_q;

  logic                            busy;
  logic                            advance;
  logic                            in_accept;
  logic                            do_step;
  cand_vec_t                       cand_now;
  cand_vec_t                       cand_next;
  logic [NUM_DIRS-1:0][ADDR_W-1:0] rd_addr;
  kind_e [NUM_DIRS-1:0]            rd_kind;
  logic  [NUM_DIRS-1:0][CNT_W-1:0] rd_cnt;
  st_wr_t                          st_wr;
  sel_t                            sel;

  assign advance    = item_vld_q && (!res_vld_q || !out_stall_i);
  assign in_stall_o = busy || (item_vld_q && !advance);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign do_step    = advance && (item_req_q == REQ_STEP);

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_accept) begin
      item_vld_d = 1'b1;
    end else if (advance) begin
      item_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  // candidates of the current position, and read addresses for the next one
  assign cand_now  = neighbours(walker_q, wrow_q, wcol_q);
  assign cand_next = neighbours(walker_d, wrow_d, wcol_d);

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      rd_addr[d] = cand_next[d].idx;
    end
  end

  gwvp_select u_select (
    .cand_i     (cand_now),
    .kind_i     (rd_kind),
    .cnt_i      (rd_cnt),
    .goal_row_i (goal_row_q),
    .goal_col_i (goal_col_q),
    .sel_o      (sel)
  );

  always_comb begin
    walker_d    = walker_q;
    wrow_d      = wrow_q;
    wcol_d      = wcol_q;
    wkind_d     = wkind_q;
    wcnt_d      = wcnt_q;
    res_moved_d = 1'b0;
    if (advance && item_req_q == REQ_LOAD && item_idx_q == walker_q) begin
      wkind_d = item_kind_q;
    end
    if (do_step && sel.found) begin
      walker_d    = sel.idx;
      wrow_d      = sel.row;
      wcol_d      = sel.col;
      wkind_d     = sel.kind;
      wcnt_d      = sel.cnt;
      res_moved_d = 1'b1;
    end
  end

  always_comb begin
    st_wr.kind_we   = advance && (item_req_q == REQ_LOAD);
    st_wr.kind_addr = item_idx_q;
    st_wr.kind_data = item_kind_q;
    st_wr.cnt_we    = do_step && sel.found;
    st_wr.cnt_addr  = sel.idx;
    st_wr.cnt_data  = sel.cnt;
  end

  gwvp_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (st_wr),
    .rd_addr_i (rd_addr),
    .rd_kind_o (rd_kind),
    .rd_cnt_o  (rd_cnt),
    .busy_o    (busy)
  );

  // goal row and column by reciprocal multiply
  assign goal_prod  = PROD_W'(cfg_wdata_i) * PROD_W'(DIV_RECIP);
  assign goal_row_d = ROW_W'(goal_prod >> DIV_SHIFT);
  assign goal_base  = ADDR_W'(ADDR_W'(goal_row_d) * ADDR_W'(GRID_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_row_q <= '0;
      goal_col_q <= '0;
    end else if (cfg_we_i) begin
      goal_row_q <= goal_row_d;
      goal_col_q <= COL_W'(cfg_wdata_i - goal_base);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      walker_q   <= WALKER_RESET;
      wrow_q     <= '0;
      wcol_q     <= COL_W'(1);
      wkind_q    <= KIND_OPEN;
      wcnt_q     <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
      walker_q   <= walker_d;
      wrow_q     <= wrow_d;
      wcol_q     <= wcol_d;
      wkind_q    <= wkind_d;
      wcnt_q     <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_req_q  <= req_e'(req_type_i);
      item_idx_q  <= cell_index_i;
      item_kind_q <= kind_e'(cell_kind_i);
    end
    if (advance) begin
      res_pos_q   <= walker_d;
      res_moved_q <= res_moved_d;
      res_goal_q  <= (wkind_d == KIND_GOAL);
      res_cnt_q   <= wcnt_d;
    end
  end

  assign out_valid_o   = res_vld_q;
  assign position_o    = res_pos_q;
  assign moved_o       = res_moved_q;
  assign at_goal_o     = res_goal_q;
  assign visit_count_o = res_cnt_q;

endmodule
